/* hdl/mec_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mec_pkg
// Shared widths, fixed-point constants and types for the escape-time colorer.
// ----------------------------------------------------------------------------
package mec_pkg;

  localparam int FRAC_BITS = 28;
  localparam int CW        = 32;
  localparam int IW        = 12;
  localparam int COLW      = 8;

  // z components entering the multipliers are bounded by 2.0 in magnitude
  localparam int ZW  = FRAC_BITS + 3;
  // floored products: squares up to 4.0, cross term up to +-4.0
  localparam int SQW = FRAC_BITS + 4;
  // updated z before the escape check
  localparam int NW  = ((CW > SQW + 1) ? CW : SQW + 1) + 2;

  localparam logic [IW-1:0] ITER_LIMIT_RST = IW'(64);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [COLW-1:0] red;
    logic [COLW-1:0] green;
    logic [COLW-1:0] blue;
  } rgb_t;

endpackage
`default_nettype wire

/* hdl/mec_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mec_if
// Valid/ready channels for points in and colored results out.
// ----------------------------------------------------------------------------
interface mec_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [mec_pkg::CW-1:0] c_re;
  logic signed [mec_pkg::CW-1:0] c_im;

  modport source (output valid, output c_re, output c_im, input ready);
  modport sink   (input valid, input c_re, input c_im, output ready);
endinterface

interface mec_out_if;
  logic                     valid;
  logic                     ready;
  logic [mec_pkg::IW-1:0]   iterations;
  logic [mec_pkg::COLW-1:0] red;
  logic [mec_pkg::COLW-1:0] green;
  logic [mec_pkg::COLW-1:0] blue;

  modport source (output valid, output iterations, output red, output green,
                  output blue, input ready);
  modport sink   (input valid, input iterations, input red, input green,
                  input blue, output ready);
endinterface
`default_nettype wire

/* hdl/mec_cplx_sq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mec_cplx_sq
// Shared complex-square unit: re*re, im*im and re*im, floored and registered.
// ----------------------------------------------------------------------------
module mec_cplx_sq (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic signed [mec_pkg::ZW-1:0]  re,
  input  wire logic signed [mec_pkg::ZW-1:0]  im,
  output logic signed [mec_pkg::SQW-1:0]      sq_re_r,
  output logic signed [mec_pkg::SQW-1:0]      sq_im_r,
  output logic signed [mec_pkg::SQW-1:0]      x_r
);
  import mec_pkg::*;

  logic signed [2*ZW-1:0] p_re;
  logic signed [2*ZW-1:0] p_im;
  logic signed [2*ZW-1:0] p_x;
  logic signed [2*ZW-1:0] s_re;
  logic signed [2*ZW-1:0] s_im;
  logic signed [2*ZW-1:0] s_x;

  assign p_re = re * re;
  assign p_im = im * im;
  assign p_x  = re * im;

  // arithmetic shift gives the floor of the scaled product
  assign s_re = p_re >>> FRAC_BITS;
  assign s_im = p_im >>> FRAC_BITS;
  assign s_x  = p_x  >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_re_r <= SQW'(s_re);
      sq_im_r <= SQW'(s_im);
      x_r     <= SQW'(s_x);
    end
  end

endmodule
`default_nettype wire

/* hdl/mec_color.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mec_color
// Banded color map of the escape count, using the count mod 17.
// ----------------------------------------------------------------------------
module mec_color (
  input  wire logic [mec_pkg::IW-1:0] n,
  input  wire logic [mec_pkg::IW-1:0] iter_limit,
  output mec_pkg::rgb_t               rgb
);
  import mec_pkg::*;

  localparam int RECIP_SHIFT = 16;
  localparam logic [IW-1:0] RECIP17 = IW'(3856);
  localparam logic [IW-1:0] MOD_BASE = IW'(17);
  localparam logic [IW-1:0] BAND_HI  = IW'(50);
  localparam logic [IW-1:0] BAND_MID = IW'(30);
  localparam logic [IW-1:0] BAND_LO  = IW'(15);

  logic [2*IW-1:0] q_prod;
  logic [IW-1:0]   q;
  logic [IW-1:0]   m_full;
  logic [4:0]      m;
  logic [COLW-1:0] m5;

  // n / 17 by reciprocal; exact for every 12-bit count
  assign q_prod = n * RECIP17;
  assign q      = IW'(q_prod >> RECIP_SHIFT);
  assign m_full = n - IW'(q * MOD_BASE);
  assign m      = m_full[4:0];
  assign m5     = COLW'({m, 2'b00}) + COLW'(m);

  always_comb begin
    if (n == iter_limit) begin
      rgb.red   = COLW'(0);
      rgb.green = COLW'(0);
      rgb.blue  = COLW'(0);
    end else if (n > BAND_HI) begin
      rgb.red   = COLW'(222) - m5;
      rgb.green = COLW'(179) - m5;
      rgb.blue  = COLW'(173);
    end else if (n > BAND_MID) begin
      rgb.red   = COLW'(222) - m5;
      rgb.green = COLW'(0);
      rgb.blue  = COLW'(123);
    end else if (n > BAND_LO) begin
      rgb.red   = COLW'(185) - m5;
      rgb.green = COLW'(92) - m5;
      rgb.blue  = COLW'(80);
    end else begin
      rgb.red   = COLW'(59) + m5;
      rgb.green = COLW'(20);
      rgb.blue  = COLW'(40);
    end
  end

endmodule
`default_nettype wire

/* hdl/mandelbrot_escape_color.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_color: escape-time counter with banded color output
// A point ends its run when z leaves the +-2.0 box at escape index n, or
// when only re^2+im^2 passes 4, or at the limit when it never escapes.
// Each step runs the complex-square multiplier, then the update adder; one
// point at a time, ready again as its result is registered.
// Synchronous active-low reset idles the block and sets the limit to 64.
// ----------------------------------------------------------------------------
`default_nettype none
module mandelbrot_escape_color (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  mec_in_if.sink                     in_chan,
  mec_out_if.source                  out_chan,
  input  wire logic                  cfg_wr_en,
  input  wire logic [mec_pkg::IW-1:0] cfg_wr_data
);
  import mec_pkg::*;

  localparam logic signed [NW-1:0]  TWO_FX  = NW'(longint'(2) << FRAC_BITS);
  localparam logic signed [SQW:0]   FOUR_FX = (SQW+1)'(longint'(4) << FRAC_BITS);

  state_t state_r, state_nxt;
  logic [IW-1:0] iter_limit_r, iter_limit_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic signed [CW-1:0] cre_r, cre_nxt;
  logic signed [CW-1:0] cim_r, cim_nxt;
  logic signed [NW-1:0] re_r, re_nxt;
  logic signed [NW-1:0] im_r, im_nxt;
  logic [IW-1:0]        k_r, k_nxt;
  logic [IW-1:0]        n_r, n_nxt;
  logic [IW-1:0]        iter_out_r, iter_out_nxt;
  rgb_t                 rgb_out_r, rgb_out_nxt;

  logic signed [SQW-1:0] sq_re;
  logic signed [SQW-1:0] sq_im;
  logic signed [SQW-1:0] x_prod;
  logic signed [SQW:0]   mag_sum;
  logic signed [NW-1:0]  re_new;
  logic signed [NW-1:0]  im_new;
  logic                  far_out;
  logic                  mul_en;
  rgb_t                  rgb;

  assign mul_en = (state_r == ST_MUL);

  mec_cplx_sq u_sq (
    .clk     (clk),
    .en      (mul_en),
    .re      (ZW'(re_r)),
    .im      (ZW'(im_r)),
    .sq_re_r (sq_re),
    .sq_im_r (sq_im),
    .x_r     (x_prod)
  );

  mec_color u_color (
    .n          (n_r),
    .iter_limit (iter_limit_r),
    .rgb        (rgb)
  );

  // a component beyond 2.0 escapes before it can reach the multipliers
  assign far_out = (re_r > TWO_FX) || (re_r < -TWO_FX) ||
                   (im_r > TWO_FX) || (im_r < -TWO_FX);
  assign mag_sum = (SQW+1)'(sq_re) + (SQW+1)'(sq_im);
  assign re_new  = NW'(sq_re) - NW'(sq_im) + NW'(cre_r);
  assign im_new  = (NW'(x_prod) <<< 1) + NW'(cim_r);

  assign in_chan.ready       = (state_r == ST_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.iterations = iter_out_r;
  assign out_chan.red        = rgb_out_r.red;
  assign out_chan.green      = rgb_out_r.green;
  assign out_chan.blue       = rgb_out_r.blue;

  always_comb begin
    state_nxt      = state_r;
    iter_limit_nxt = cfg_wr_en ? cfg_wr_data : iter_limit_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    cre_nxt        = cre_r;
    cim_nxt        = cim_r;
    re_nxt         = re_r;
    im_nxt         = im_r;
    k_nxt          = k_r;
    n_nxt          = n_r;
    iter_out_nxt   = iter_out_r;
    rgb_out_nxt    = rgb_out_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          cre_nxt   = in_chan.c_re;
          cim_nxt   = in_chan.c_im;
          re_nxt    = '0;
          im_nxt    = '0;
          k_nxt     = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if ((k_r != '0) && far_out) begin
          n_nxt     = k_r - IW'(1);
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if ((k_r != '0) && (mag_sum > FOUR_FX)) begin
          n_nxt     = k_r - IW'(1);
          state_nxt = ST_DONE;
        end else if (k_r == iter_limit_r) begin
          n_nxt     = iter_limit_r;
          state_nxt = ST_DONE;
        end else begin
          re_nxt    = re_new;
          im_nxt    = im_new;
          k_nxt     = k_r + IW'(1);
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: begin
        // wait here while the previous request still sits in the output register
        if (!out_valid_r || out_chan.ready) begin
          iter_out_nxt  = n_r;
          rgb_out_nxt   = rgb;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      iter_limit_r <= ITER_LIMIT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      iter_limit_r <= iter_limit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cre_r      <= cre_nxt;
    cim_r      <= cim_nxt;
    re_r       <= re_nxt;
    im_r       <= im_nxt;
    k_r        <= k_nxt;
    n_r        <= n_nxt;
    iter_out_r <= iter_out_nxt;
    rgb_out_r  <= rgb_out_nxt;
  end

endmodule
`default_nettype wire
